// ----- sv/pond_pkg.sv -----
// ----------------------------------------------------------------------------
// pond_pkg
// shared types, constants and helpers for the 2d octave gradient noise core
// ----------------------------------------------------------------------------
package pond_pkg;

   localparam logic [31:0] MIX_M = 32'h5bd1e995;
   localparam int ACC_W = 32;
   localparam int CONTRIB_W = 24;

   localparam logic [2:0] REG_NOISE_SEED   = 3'd0;
   localparam logic [2:0] REG_BASE_FREQ    = 3'd1;
   localparam logic [2:0] REG_OCTAVE_COUNT = 3'd2;
   localparam logic [2:0] REG_PERSISTENCE  = 3'd3;
   localparam logic [2:0] REG_LACUNARITY   = 3'd4;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] noise_sum;
      logic [15:0]        noise_unit;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] noise_seed;
      logic [7:0]  base_frequency;
      logic [3:0]  octave_num;
      logic [15:0] persistence_q16;
      logic [15:0] lacunarity_q12;
   } cfg_type;

   typedef struct packed {
      logic [31:0] seed;
      logic [31:0] freq;
      logic [16:0] amp;
   } oct_param_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [31:0]        seed;
      logic [31:0]        freq;
      logic [16:0]        amp;
      logic               first;
      logic               last;
      logic               null_oct;
   } slot_type;

   typedef struct packed {
      logic                        valid;
      logic signed [CONTRIB_W-1:0] contrib;
      logic                        first;
      logic                        last;
   } part_type;

   typedef enum logic [2:0] {
      TB_IDLE,
      TB_LOAD,
      TB_MUL1,
      TB_MUL2,
      TB_MUL3
   } tb_state_type;

   function automatic logic [31:0] mul_m(input logic [31:0] a);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, MIX_M};
      return p[31:0];
   endfunction

   function automatic logic signed [18:0] grad_dot(input logic [2:0] g,
                                                   input logic signed [17:0] ox,
                                                   input logic signed [17:0] oy);
      logic signed [18:0] x;
      logic signed [18:0] y;
      logic signed [18:0] r;
      x = {ox[17], ox};
      y = {oy[17], oy};
      case (g)
         3'd0: r = x + y;
         3'd1: r = y - x;
         3'd2: r = x - y;
         3'd3: r = -x - y;
         3'd4: r = x;
         3'd5: r = -x;
         3'd6: r = y;
         default: r = -y;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/pond_octave_table.sv -----
// ----------------------------------------------------------------------------
// pond_octave_table
// per-octave seed, frequency and amplitude, rebuilt after reset and each write
// ----------------------------------------------------------------------------
module pond_octave_table import pond_pkg::*; #(
   parameter int MAX_OCTAVES = 8,
   parameter int KW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          rebuild,
   input  logic [KW-1:0] rd_idx,
   output oct_param_type rd_entry,
   output logic          busy
);

   tb_state_type state_ff, state_in;
   oct_param_type tab_ff [MAX_OCTAVES];
   logic [31:0] seed_ff, k_ff, freq_ff;
   logic [16:0] amp_ff;
   logic [KW-1:0] idx_ff;
   logic [31:0] k2, h1, h2, new_seed;
   logic [47:0] nf;
   logic [32:0] na;
   logic [31:0] freq_in;
   logic tab_we;

   assign k2 = mul_m(k_ff ^ (k_ff >> 24));
   assign h1 = k_ff ^ (k_ff >> 13);
   assign h2 = mul_m(h1);
   assign new_seed = h2 ^ (h2 >> 15);
   assign nf = {16'd0, freq_ff} * {32'd0, cfg.lacunarity_q12};
   assign na = {16'd0, amp_ff} * {17'd0, cfg.persistence_q16};
   assign freq_in = (nf[47:44] != 4'd0) ? 32'hFFFF_FFFF : nf[43:12];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TB_IDLE: state_in = TB_IDLE;
         TB_LOAD: state_in = TB_MUL1;
         TB_MUL1: state_in = TB_MUL2;
         TB_MUL2: state_in = TB_MUL3;
         TB_MUL3: state_in = (idx_ff == KW'(MAX_OCTAVES - 1)) ? TB_IDLE : TB_MUL1;
         default: state_in = TB_LOAD;
      endcase
      // a write restarts the rebuild from the top
      if (rebuild) state_in = TB_LOAD;
   end

   always_comb begin
      busy = 1'b1;
      tab_we = 1'b0;
      unique case (state_ff)
         TB_IDLE: busy = 1'b0;
         TB_MUL3: tab_we = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TB_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         TB_LOAD: begin
            seed_ff <= cfg.noise_seed;
            freq_ff <= {12'd0, cfg.base_frequency, 12'd0};
            amp_ff  <= 17'h10000;
            idx_ff  <= '0;
         end
         TB_MUL1: k_ff <= mul_m(seed_ff);
         TB_MUL2: k_ff <= k2;
         TB_MUL3: begin
            seed_ff <= new_seed;
            freq_ff <= freq_in;
            amp_ff  <= na[32:16];
            idx_ff  <= idx_ff + KW'(1);
         end
         default: ;
      endcase
      if (tab_we) begin
         tab_ff[idx_ff] <= '{seed: new_seed, freq: freq_ff, amp: amp_ff};
      end
   end

   assign rd_entry = tab_ff[rd_idx];

endmodule

// ----- sv/pond_front.sv -----
// ----------------------------------------------------------------------------
// pond_front
// input queue and octave issue, one octave slot per cycle while adv is high
// ----------------------------------------------------------------------------
module pond_front import pond_pkg::*; #(
   parameter int MAX_OCTAVES = 8,
   parameter int KW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   input  logic [3:0]      octave_num,
   input  logic            table_busy,
   input  logic            adv,
   output logic [KW-1:0]   tab_idx,
   input  oct_param_type   tab_entry,
   output slot_type        slot
);

   typedef struct packed {
      req_payload_type pos;
      logic [KW-1:0]   last_k;
      logic            null_oct;
   } qent_type;

   qent_type q_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic [KW-1:0] k_ff;
   logic [4:0] oc_eff;
   qent_type went, head;
   logic push, pop, issue, is_last;

   assign oc_eff = ({1'b0, octave_num} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                         : {1'b0, octave_num};
   assign went.pos = req_data;
   assign went.null_oct = (octave_num == 4'd0);
   assign went.last_k = (octave_num == 4'd0) ? KW'(0) : KW'(oc_eff - 5'd1);

   assign req_ready = !table_busy && (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign head = q_ff[rd_ff];
   assign issue = adv && (cnt_ff != 2'd0);
   assign is_last = head.null_oct || (k_ff == head.last_k);
   assign pop = issue && is_last;
   assign tab_idx = k_ff;

   always_comb begin
      slot.valid    = issue;
      slot.px       = head.pos.pos_x;
      slot.py       = head.pos.pos_y;
      slot.seed     = tab_entry.seed;
      slot.freq     = tab_entry.freq;
      slot.amp      = tab_entry.amp;
      slot.first    = (k_ff == KW'(0));
      slot.last     = is_last;
      slot.null_oct = head.null_oct;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
         k_ff   <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
         if (issue) k_ff <= is_last ? KW'(0) : k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= went;
   end

endmodule

// ----- sv/pond_octave_pipe.sv -----
// ----------------------------------------------------------------------------
// pond_octave_pipe
// nine-stage octave evaluator: lattice split, corner hashes, fade, blend, weight
// ----------------------------------------------------------------------------
module pond_octave_pipe import pond_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  slot_type slot,
   output part_type part
);

   logic [9:1] v_ff;
   logic [9:1] fi_ff, la_ff, nu_ff;
   logic [16:0] amp_ff [8:1];

   // stage 1
   logic signed [64:0] mx, my;
   logic [31:0] s1_cx_ff, s1_cy_ff, s1_h0_ff;
   logic [15:0] s1_tx_ff, s1_ty_ff;
   assign mx = slot.px * $signed({1'b0, slot.freq});
   assign my = slot.py * $signed({1'b0, slot.freq});

   // stage 2
   logic [19:0] ax, ay;
   logic [31:0] s2_k_ff [4];
   logic [35:0] s2_tax_ff, s2_tay_ff;
   logic [15:0] s2_tx_ff, s2_ty_ff;
   logic [31:0] s2_h0_ff;
   assign ax = 20'd983040 - ({4'd0, s1_tx_ff} * 20'd6);
   assign ay = 20'd983040 - ({4'd0, s1_ty_ff} * 20'd6);

   // stage 3
   logic [19:0] bx, by;
   logic [31:0] s3_k_ff [4];
   logic [35:0] s3_tbx_ff, s3_tby_ff;
   logic [15:0] s3_tx_ff, s3_ty_ff;
   logic [31:0] s3_h0_ff;
   assign bx = 20'd655360 - s2_tax_ff[35:16];
   assign by = 20'd655360 - s2_tay_ff[35:16];

   // stage 4
   logic [31:0] s4_hx_ff [2];
   logic [31:0] s4_ky_ff [2];
   logic [35:0] s4_tcx_ff, s4_tcy_ff;
   logic [15:0] s4_tx_ff, s4_ty_ff;

   // stage 5
   logic [31:0] s5_h_ff [4];
   logic [35:0] s5_tdx_ff, s5_tdy_ff;
   logic [15:0] s5_tx_ff, s5_ty_ff;
   logic [31:0] hm [4];

   // stage 6
   logic signed [17:0] ox0, ox1, oy0, oy1;
   logic [2:0] g [4];
   logic signed [18:0] s6_v_ff [4];
   logic [16:0] s6_sx_ff, s6_sy_ff;

   // stage 7
   logic signed [19:0] d1, d2;
   logic signed [37:0] p1, p2, p1s, p2s;
   logic signed [20:0] s7_m1_ff, s7_m2_ff;
   logic [16:0] s7_sy_ff;

   // stage 8
   logic signed [21:0] d3;
   logic signed [39:0] p3, p3s;
   logic signed [21:0] s8_r_ff;

   // stage 9
   logic signed [39:0] pa, pas;
   logic signed [CONTRIB_W-1:0] s9_c_ff;

   assign ox0 = $signed({2'b00, s5_tx_ff});
   assign ox1 = $signed({2'b00, s5_tx_ff}) - 18'sd65536;
   assign oy0 = $signed({2'b00, s5_ty_ff});
   assign oy1 = $signed({2'b00, s5_ty_ff}) - 18'sd65536;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hm[i] = s4_hx_ff[i % 2] ^ s4_ky_ff[i / 2];
         g[i] = s5_h_ff[i][2:0] ^ s5_h_ff[i][17:15];
      end
   end

   assign d1 = {s6_v_ff[1][18], s6_v_ff[1]} - {s6_v_ff[0][18], s6_v_ff[0]};
   assign d2 = {s6_v_ff[3][18], s6_v_ff[3]} - {s6_v_ff[2][18], s6_v_ff[2]};
   assign p1 = $signed({1'b0, s6_sx_ff}) * d1;
   assign p2 = $signed({1'b0, s6_sx_ff}) * d2;
   assign p1s = p1 >>> 16;
   assign p2s = p2 >>> 16;

   assign d3 = {s7_m2_ff[20], s7_m2_ff} - {s7_m1_ff[20], s7_m1_ff};
   assign p3 = $signed({1'b0, s7_sy_ff}) * d3;
   assign p3s = p3 >>> 16;

   assign pa = s8_r_ff * $signed({1'b0, amp_ff[8]});
   assign pas = pa >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[8:1], slot.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fi_ff <= {fi_ff[8:1], slot.first};
         la_ff <= {la_ff[8:1], slot.last};
         nu_ff <= {nu_ff[8:1], slot.null_oct};
         amp_ff[1] <= slot.amp;
         for (int i = 2; i <= 8; i++) amp_ff[i] <= amp_ff[i - 1];

         s1_cx_ff <= mx[59:28];
         s1_cy_ff <= my[59:28];
         s1_tx_ff <= mx[27:12];
         s1_ty_ff <= my[27:12];
         s1_h0_ff <= mul_m(slot.seed);

         s2_k_ff[0] <= mul_m(s1_cx_ff);
         s2_k_ff[1] <= mul_m(s1_cx_ff + 32'd1);
         s2_k_ff[2] <= mul_m(s1_cy_ff);
         s2_k_ff[3] <= mul_m(s1_cy_ff + 32'd1);
         s2_tax_ff <= {20'd0, s1_tx_ff} * {16'd0, ax};
         s2_tay_ff <= {20'd0, s1_ty_ff} * {16'd0, ay};
         s2_tx_ff <= s1_tx_ff;
         s2_ty_ff <= s1_ty_ff;
         s2_h0_ff <= s1_h0_ff;

         for (int i = 0; i < 4; i++) s3_k_ff[i] <= mul_m(s2_k_ff[i] ^ (s2_k_ff[i] >> 24));
         s3_tbx_ff <= {20'd0, s2_tx_ff} * {16'd0, bx};
         s3_tby_ff <= {20'd0, s2_ty_ff} * {16'd0, by};
         s3_tx_ff <= s2_tx_ff;
         s3_ty_ff <= s2_ty_ff;
         s3_h0_ff <= s2_h0_ff;

         s4_hx_ff[0] <= mul_m(s3_h0_ff ^ s3_k_ff[0]);
         s4_hx_ff[1] <= mul_m(s3_h0_ff ^ s3_k_ff[1]);
         s4_ky_ff[0] <= s3_k_ff[2];
         s4_ky_ff[1] <= s3_k_ff[3];
         s4_tcx_ff <= {20'd0, s3_tx_ff} * {16'd0, s3_tbx_ff[35:16]};
         s4_tcy_ff <= {20'd0, s3_ty_ff} * {16'd0, s3_tby_ff[35:16]};
         s4_tx_ff <= s3_tx_ff;
         s4_ty_ff <= s3_ty_ff;

         for (int i = 0; i < 4; i++) s5_h_ff[i] <= mul_m(hm[i] ^ (hm[i] >> 13));
         s5_tdx_ff <= {20'd0, s4_tx_ff} * {16'd0, s4_tcx_ff[35:16]};
         s5_tdy_ff <= {20'd0, s4_ty_ff} * {16'd0, s4_tcy_ff[35:16]};
         s5_tx_ff <= s4_tx_ff;
         s5_ty_ff <= s4_ty_ff;

         s6_v_ff[0] <= grad_dot(g[0], ox0, oy0);
         s6_v_ff[1] <= grad_dot(g[1], ox1, oy0);
         s6_v_ff[2] <= grad_dot(g[2], ox0, oy1);
         s6_v_ff[3] <= grad_dot(g[3], ox1, oy1);
         s6_sx_ff <= s5_tdx_ff[32:16];
         s6_sy_ff <= s5_tdy_ff[32:16];

         s7_m1_ff <= {{2{s6_v_ff[0][18]}}, s6_v_ff[0]} + p1s[20:0];
         s7_m2_ff <= {{2{s6_v_ff[2][18]}}, s6_v_ff[2]} + p2s[20:0];
         s7_sy_ff <= s6_sy_ff;

         s8_r_ff <= {s7_m1_ff[20], s7_m1_ff} + p3s[21:0];

         s9_c_ff <= nu_ff[8] ? '0 : pas[CONTRIB_W-1:0];
      end
   end

   assign part.valid   = v_ff[9];
   assign part.contrib = s9_c_ff;
   assign part.first   = fi_ff[9];
   assign part.last    = la_ff[9];

endmodule

// ----- sv/pond_accum.sv -----
// ----------------------------------------------------------------------------
// pond_accum
// octave sum, output scaling and two-deep result queue
// ----------------------------------------------------------------------------
module pond_accum import pond_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  part_type        part,
   output logic            adv,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic signed [ACC_W-1:0] acc_ff, sum_new, res_sum_ff, q, u;
   logic res_v_ff;
   rsp_payload_type fifo_ff [2];
   rsp_payload_type res;
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign adv = (cnt_ff != 2'd2);
   assign sum_new = (part.first ? '0 : acc_ff)
                  + {{(ACC_W-CONTRIB_W){part.contrib[CONTRIB_W-1]}}, part.contrib};
   assign q = res_sum_ff >>> 4;
   assign u = (res_sum_ff + ACC_W'(65536)) >>> 1;

   always_comb begin
      if (q > ACC_W'(32767)) res.noise_sum = 16'sh7FFF;
      else if (q < -ACC_W'(32768)) res.noise_sum = 16'sh8000;
      else res.noise_sum = q[15:0];
      if (u < 0) res.noise_unit = 16'd0;
      else if (u > ACC_W'(65535)) res.noise_unit = 16'hFFFF;
      else res.noise_unit = u[15:0];
   end

   assign push = adv && res_v_ff;
   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data = fifo_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         if (adv) res_v_ff <= part.valid && part.last;
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv && part.valid) begin
         acc_ff     <= sum_new;
         res_sum_ff <= sum_new;
      end
      if (push) fifo_ff[wr_ff] <= res;
   end

endmodule

// ----- sv/perlin_octave_noise_2d_core.sv -----
// ----------------------------------------------------------------------------
// perlin_octave_noise_2d_core
// fractal 2d gradient noise from signed q16.16 positions
// ----------------------------------------------------------------------------
// One position takes max(1, min(octave_num, MAX_OCTAVES)) octave slots: the
// octave evaluator takes one octave slot per cycle while the result queue is not
// full, so back-to-back positions stream at that rate. After reset and after every
// register write the per-octave seed/frequency/amplitude table is rebuilt, and
// req_ready stays low while it is.
module perlin_octave_noise_2d_core import pond_pkg::*; #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [4:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam int KW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

   cfg_type cfg_ff;
   logic wr;
   logic busy, adv;
   logic [KW-1:0] tab_idx;
   oct_param_type tab_entry;
   slot_type slot;
   part_type part;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{noise_seed: 32'd0, base_frequency: 8'd1, octave_num: 4'd4,
                     persistence_q16: 16'h8000, lacunarity_q12: 16'h2000};
      end else if (wr) begin
         case (paddr[4:2])
            REG_NOISE_SEED:   cfg_ff.noise_seed      <= pwdata;
            REG_BASE_FREQ:    cfg_ff.base_frequency  <= pwdata[7:0];
            REG_OCTAVE_COUNT: cfg_ff.octave_num      <= pwdata[3:0];
            REG_PERSISTENCE:  cfg_ff.persistence_q16 <= pwdata[15:0];
            REG_LACUNARITY:   cfg_ff.lacunarity_q12  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_NOISE_SEED:   prdata = cfg_ff.noise_seed;
         REG_BASE_FREQ:    prdata = {24'd0, cfg_ff.base_frequency};
         REG_OCTAVE_COUNT: prdata = {28'd0, cfg_ff.octave_num};
         REG_PERSISTENCE:  prdata = {16'd0, cfg_ff.persistence_q16};
         REG_LACUNARITY:   prdata = {16'd0, cfg_ff.lacunarity_q12};
         default:          prdata = 32'd0;
      endcase
   end

   pond_octave_table #(.MAX_OCTAVES(MAX_OCTAVES), .KW(KW)) u_table (
      .clock, .reset, .cfg(cfg_ff), .rebuild(wr),
      .rd_idx(tab_idx), .rd_entry(tab_entry), .busy
   );

   pond_front #(.MAX_OCTAVES(MAX_OCTAVES), .KW(KW)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .octave_num(cfg_ff.octave_num), .table_busy(busy), .adv,
      .tab_idx, .tab_entry, .slot
   );

   pond_octave_pipe u_pipe (
      .clock, .reset, .adv, .slot, .part
   );

   pond_accum u_accum (
      .clock, .reset, .part, .adv, .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

// ----- tb/perlin_octave_noise_2d_checker.sv -----
// ----------------------------------------------------------------------------
// perlin_octave_noise_2d_checker
// watches the register port and both channels, predicts the octave noise sum
// and unit value for every accepted position and compares each result beat
// ----------------------------------------------------------------------------
module perlin_octave_noise_2d_checker import pond_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [4:0]      paddr,
   input  logic [31:0]     pwdata,
   input  logic            pready,
   output int              mismatch_count,
   output int              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OCTAVE_LIMIT = 8;

   logic [31:0] seed_q;
   logic [7:0]  base_freq_q;
   logic [3:0]  octaves_q;
   logic [15:0] persist_q;
   logic [15:0] lacun_q;

   rsp_payload_type noise_expected[$];

   function automatic logic [31:0] scramble_key(input logic [31:0] k);
      logic [31:0] v;
      v = k * MIX_M;
      v = v ^ (v >> 24);
      return v * MIX_M;
   endfunction

   function automatic logic [31:0] scramble_final(input logic [31:0] h);
      logic [31:0] v;
      v = h ^ (h >> 13);
      v = v * MIX_M;
      return v ^ (v >> 15);
   endfunction

   function automatic logic [31:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
                                               input logic [31:0] seed);
      logic [31:0] h;
      h = seed * MIX_M;
      h = h ^ scramble_key(cx);
      h = h * MIX_M;
      h = h ^ scramble_key(cy);
      return scramble_final(h);
   endfunction

   function automatic longint gradient_dot(input logic [31:0] h, input longint ox,
                                           input longint oy);
      case (h[2:0])
         3'd0: return ox + oy;
         3'd1: return oy - ox;
         3'd2: return ox - oy;
         3'd3: return -ox - oy;
         3'd4: return ox;
         3'd5: return -ox;
         3'd6: return oy;
         default: return -oy;
      endcase
   endfunction

   function automatic longint quintic_fade(input longint t_in);
      logic [63:0] t, a, b, c, d, e;
      t = t_in;
      a = 64'd983040 - 64'd6 * t;
      b = 64'd655360 - ((t * a) >> 16);
      c = (t * b) >> 16;
      d = (t * c) >> 16;
      e = (t * d) >> 16;
      return longint'(e);
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint s);
      return a + ((s * (b - a)) >>> 16);
   endfunction

   function automatic longint octave_value(input longint px, input longint py,
                                           input logic [31:0] freq, input logic [31:0] seed);
      logic [63:0] ux, uy;
      logic [31:0] cx, cy;
      longint fx, fy, v1, v2, v3, v4, sx, sy;
      ux = px * longint'({32'd0, freq});
      uy = py * longint'({32'd0, freq});
      cx = ux[59:28];
      cy = uy[59:28];
      fx = longint'({48'd0, ux[27:12]});
      fy = longint'({48'd0, uy[27:12]});
      v1 = gradient_dot(lattice_hash(cx, cy, seed), fx, fy);
      v2 = gradient_dot(lattice_hash(cx + 1, cy, seed), fx - 65536, fy);
      v3 = gradient_dot(lattice_hash(cx, cy + 1, seed), fx, fy - 65536);
      v4 = gradient_dot(lattice_hash(cx + 1, cy + 1, seed), fx - 65536, fy - 65536);
      sx = quintic_fade(fx);
      sy = quintic_fade(fy);
      return blend(blend(v1, v2, sx), blend(v3, v4, sx), sy);
   endfunction

   function automatic rsp_payload_type predict_noise(input req_payload_type p);
      rsp_payload_type r;
      longint px, py, sum, q, unit;
      logic [31:0] seed, freq;
      logic [63:0] amp, nf;
      int count;
      px = longint'(p.pos_x);
      py = longint'(p.pos_y);
      count = (octaves_q > OCTAVE_LIMIT) ? OCTAVE_LIMIT : int'(octaves_q);
      seed = seed_q;
      freq = {12'd0, base_freq_q, 12'd0};
      amp = 64'd65536;
      sum = 0;
      for (int i = 0; i < count; i++) begin
         seed = scramble_final(scramble_key(seed));
         sum += (octave_value(px, py, freq, seed) * longint'(amp)) >>> 16;
         amp = (amp * {48'd0, persist_q}) >> 16;
         nf = ({32'd0, freq} * {48'd0, lacun_q}) >> 12;
         freq = (nf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nf[31:0];
      end
      q = sum >>> 4;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      unit = (sum + 65536) >>> 1;
      if (unit < 0) unit = 0;
      if (unit > 65535) unit = 65535;
      r.noise_sum = q[15:0];
      r.noise_unit = unit[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      int delta;
      if (reset) begin
         seed_q <= '0;
         base_freq_q <= 8'd1;
         octaves_q <= 4'd4;
         persist_q <= 16'h8000;
         lacun_q <= 16'h2000;
         noise_expected.delete();
         mismatch_count <= 0;
         pending_count <= 0;
      end else begin
         delta = 0;
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_NOISE_SEED:   seed_q <= pwdata;
               REG_BASE_FREQ:    base_freq_q <= pwdata[7:0];
               REG_OCTAVE_COUNT: octaves_q <= pwdata[3:0];
               REG_PERSISTENCE:  persist_q <= pwdata[15:0];
               REG_LACUNARITY:   lacun_q <= pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            noise_expected.push_back(predict_noise(req_data));
            delta++;
         end
         if (rsp_valid && rsp_ready) begin
            if (noise_expected.size() == 0) begin
               $error("result beat with nothing expected: sum %0d unit %0d",
                      rsp_data.noise_sum, rsp_data.noise_unit);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = noise_expected.pop_front();
               delta--;
               if (want.noise_sum !== rsp_data.noise_sum ||
                   want.noise_unit !== rsp_data.noise_unit)
                  mismatch_count <= mismatch_count + 1;
               if (want.noise_sum !== rsp_data.noise_sum)
                  $error("noise_sum expected %0d actual %0d",
                         want.noise_sum, rsp_data.noise_sum);
               if (want.noise_unit !== rsp_data.noise_unit)
                  $error("noise_unit expected %0d actual %0d",
                         want.noise_unit, rsp_data.noise_unit);
            end
         end
         pending_count <= pending_count + delta;
      end
   end

endmodule

// ----- tb/tb_perlin_octave_noise_2d_core.sv -----
// ----------------------------------------------------------------------------
// tb_perlin_octave_noise_2d_core
// drives positions and register settings into the octave noise core with random
// idling on both sides and a long receiver stall; the checker gives the verdict
// ----------------------------------------------------------------------------
module tb_perlin_octave_noise_2d_core import pond_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 4000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            psel = 1'b0;
   logic            penable = 1'b0;
   logic            pwrite = 1'b0;
   logic [4:0]      paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;

   int mismatch_count;
   int pending_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic stall_kick = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   perlin_octave_noise_2d_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   perlin_octave_noise_2d_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   // receiver side, long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_kick) begin
         rsp_ready <= 1'b0;
         stall_left <= 400;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL perlin_octave_noise_2d_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] seed, input logic [7:0] freq,
                                input logic [3:0] octaves, input logic [15:0] persist,
                                input logic [15:0] lacun);
      write_reg(REG_NOISE_SEED, seed);
      write_reg(REG_BASE_FREQ, {24'd0, freq});
      write_reg(REG_OCTAVE_COUNT, {28'd0, octaves});
      write_reg(REG_PERSISTENCE, {16'd0, persist});
      write_reg(REG_LACUNARITY, {16'd0, lacun});
   endtask

   task automatic send_position(input logic [31:0] x, input logic [31:0] y);
      int gap;
      req_valid <= 1'b1;
      req_data.pos_x <= x;
      req_data.pos_y <= y;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      logic [31:0] v;
      case ($urandom_range(4))
         0: v = $urandom();
         1: v = $urandom_range(32'h0040_0000) - 32'h0020_0000;
         2: v = {16'($urandom_range(65535)), 16'hFFFF ^ 16'($urandom_range(3))};
         3: v = {16'($urandom()), 16'($urandom_range(3))};
         default: v = $urandom_range(32'h0001_0000);
      endcase
      return v;
   endfunction

   initial begin
      logic [31:0] edge_vals [8];
      edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                    32'h0001_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_8000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, coordinate extremes
      for (int i = 0; i < 8; i++)
         send_position(edge_vals[i], edge_vals[(i * 3 + 1) % 8]);
      send_position(32'h8000_0000, 32'h8000_0000);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain_results();
      // zero octaves, zero frequency, saturated octave count, frequency overflow
      load_settings(32'hFFFF_FFFF, 8'd0, 4'd0, 16'hFFFF, 16'h0);
      send_position(32'h1234_5678, 32'h8765_4321);
      drain_results();
      write_reg(3'd7, 32'hDEAD_BEEF);
      load_settings(32'h0, 8'd255, 4'd15, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 8; i++)
         send_position(edge_vals[i], edge_vals[7 - i]);
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_settings($urandom(), 8'd1, 4'd8, 16'hFFFF, 16'hFFFF);
            1: load_settings(32'hFFFF_FFFF, 8'd255, 4'd1, 16'h0, 16'h1000);
            2: load_settings($urandom(), 8'd0, 4'd3, 16'h8000, 16'h0);
            3: load_settings($urandom(), 8'($urandom_range(1, 255)), 4'd0,
                             16'($urandom()), 16'($urandom()));
            4: load_settings(32'h0, 8'd7, 4'd15, 16'($urandom()), 16'($urandom()));
            default: load_settings($urandom(), 8'd2, 4'd5, 16'h8000, 16'h2000);
         endcase
         send_idle_pct = (phase < 2) ? 17 : (phase < 4) ? 78 : 0;
         recv_idle_pct = (phase < 2) ? 78 : (phase < 4) ? 17 : 0;
         for (int n = 0; n < 235; n++) begin
            if (phase == 1 && n == 40) begin
               req_valid <= 1'b0;
               stall_kick <= 1'b1;
               send_idle_pct = 0;
               @(posedge clock);
               stall_kick <= 1'b0;
            end
            if (phase == 1 && n == 120)
               send_idle_pct = 17;
            if (phase == 3 && n == 100)
               drain_results();
            send_position(random_coord(), random_coord());
         end
         drain_results();
      end

      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS perlin_octave_noise_2d_core");
      else
         $display("FAIL perlin_octave_noise_2d_core");
      $finish;
   end

endmodule
